/* src/esd_pkg.sv */
// Package: shared types, character constants and helper functions for the escape decoder.
package esd_pkg;

    // Escape state of the decoder
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_BS1   = 3'd1,
        MODE_BS2   = 3'd2,
        MODE_BS3   = 3'd3,
        MODE_CARET = 3'd4
    } esd_mode_t;

    // Input item kinds
    localparam logic ACT_CHAR  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Character constants
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CARET_MASK = 8'h1F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;

    // Result queue depth; an item is taken only when two entries are free
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded result as stored in the queue
    typedef struct packed {
        logic [7:0] byte_out;
        logic       last;
    } esd_result_t;

    // Outcome of decoding one input item against the current state
    typedef struct packed {
        esd_mode_t  mode;
        logic [7:0] acc;
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } esd_step_t;

    // Map a letter after a backslash to its control character
    function automatic logic [7:0] control_of(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

    // True for '0'..'7'
    function automatic logic is_octal(input logic [7:0] c);
        return c[7:3] == CH_ZERO[7:3];
    endfunction

endpackage

/* src/esd_in_if.sv */
// Interface: input channel carrying action and character with valid/ready.
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_in;

    modport source (output valid, output action, output char_in, input ready);
    modport sink   (input valid, input action, input char_in, output ready);
endinterface

/* src/esd_out_if.sv */
// Interface: output channel carrying decoded bytes with valid/ready.
interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last;

    modport source (output valid, output byte_out, output last, input ready);
    modport sink   (input valid, input byte_out, input last, output ready);
endinterface

/* src/esd_decode.sv */
// Module: combinational step of the escape decoder (next state and up to two bytes).
module esd_decode (
    input  esd_pkg::esd_mode_t mode,
    input  logic [7:0]         acc,
    input  logic               action,
    input  logic [7:0]         char_in,
    output esd_pkg::esd_step_t step
);
    import esd_pkg::*;

    logic       oct;
    logic [7:0] acc_shift;

    assign oct       = is_octal(char_in);
    assign acc_shift = {acc[4:0], char_in[2:0]};

    // Decode one item against the current escape state
    always_comb
    begin
        step.mode  = MODE_IDLE;
        step.acc   = acc;
        step.count = 2'd0;
        step.byte0 = char_in;
        step.byte1 = char_in;

        if (action == ACT_FLUSH)
        begin
            // Flush a pending escape and clear the state
            step.acc = 8'd0;
            case (mode)
                MODE_BS1, MODE_BS2, MODE_BS3:
                begin
                    step.count = 2'd1;
                    step.byte0 = acc;
                end
                MODE_CARET:
                begin
                    step.count = 2'd1;
                    step.byte0 = CH_CARET;
                end
                default:
                begin
                    step.count = 2'd0;
                end
            endcase
        end
        else
        begin
            case (mode)
                MODE_BS1:
                begin
                    if (oct)
                    begin
                        step.acc  = acc_shift;
                        step.mode = MODE_BS2;
                    end
                    else
                    begin
                        step.count = 2'd1;
                        step.byte0 = control_of(char_in);
                    end
                end
                MODE_BS2, MODE_BS3:
                begin
                    if (oct)
                    begin
                        step.acc = acc_shift;
                        if (mode == MODE_BS2)
                        begin
                            step.mode = MODE_BS3;
                        end
                        else
                        begin
                            step.count = 2'd1;
                            step.byte0 = acc_shift;
                        end
                    end
                    else
                    begin
                        // Short run ended: emit the value, then handle the char as idle
                        step.byte0 = acc;
                        if (char_in == CH_BSLASH)
                        begin
                            step.count = 2'd1;
                            step.mode  = MODE_BS1;
                            step.acc   = 8'd0;
                        end
                        else if (char_in == CH_CARET)
                        begin
                            step.count = 2'd1;
                            step.mode  = MODE_CARET;
                        end
                        else
                        begin
                            step.count = 2'd2;
                            step.byte1 = char_in;
                        end
                    end
                end
                MODE_CARET:
                begin
                    step.count = 2'd1;
                    step.byte0 = (char_in == CH_QMARK) ? CH_DEL : (char_in & CARET_MASK);
                end
                default:
                begin
                    if (char_in == CH_BSLASH)
                    begin
                        step.mode = MODE_BS1;
                        step.acc  = 8'd0;
                    end
                    else if (char_in == CH_CARET)
                    begin
                        step.mode = MODE_CARET;
                    end
                    else
                    begin
                        step.count = 2'd1;
                    end
                end
            endcase
        end
    end

endmodule

/* src/escape_sequence_decoder.sv */
// Results are registered in the result queue and presented from its head.
// Throughput: one input item per cycle while two queue entries are free; the decode
// state sits in two registers and a four-entry result queue lets input continue while
// results wait. An item that gives two bytes takes two output transfers.
// Reset: asynchronous, active low; clears escape state and empties the queue.
module escape_sequence_decoder (
    input  logic      clk,
    input  logic      rst_n,
    esd_in_if.sink    in_chan,
    esd_out_if.source out_chan
);
    import esd_pkg::*;

    esd_mode_t         mode_reg, mode_next;
    logic [7:0]        acc_reg, acc_next;
    esd_step_t         step;

    esd_result_t       queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic              in_xfer;
    logic              out_xfer;
    logic [QPTR_W-1:0] wr_ptr_inc;

    // Take an item only when two queue entries are free
    assign in_chan.ready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign in_xfer       = in_chan.valid & in_chan.ready;

    assign out_chan.valid    = (count_reg != '0);
    assign out_chan.byte_out = queue_reg[rd_ptr_reg].byte_out;
    assign out_chan.last     = queue_reg[rd_ptr_reg].last;
    assign out_xfer          = out_chan.valid & out_chan.ready;

    esd_decode u_decode (
        .mode    (mode_reg),
        .acc     (acc_reg),
        .action  (in_chan.action),
        .char_in (in_chan.char_in),
        .step    (step)
    );

    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);

    // Advance state and queue pointers
    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_xfer)
        begin
            mode_next   = step.mode;
            acc_next    = step.acc;
            wr_ptr_next = wr_ptr_reg + QPTR_W'(step.count);
            count_next  = count_reg + QCNT_W'(step.count);
        end
        if (out_xfer)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            count_next  = count_next - QCNT_W'(1);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= 8'd0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write decoded bytes into the queue; last marks the final byte of the item
    always_ff @(posedge clk)
    begin
        if (in_xfer && step.count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= '{byte_out: step.byte0, last: (step.count == 2'd1)};
            if (step.count == 2'd2)
            begin
                queue_reg[wr_ptr_inc] <= '{byte_out: step.byte1, last: 1'b1};
            end
        end
    end

endmodule
